FILE: hdl/v3a_pkg.sv
// Shared types, constants and saturation helpers for the three-component vector ALU.
// No dependencies; every other file imports this package.
package v3a_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LANES     = 3;
    localparam int DW        = 32;
    localparam int PROD_W    = 2 * DW;
    localparam int ACC_W     = PROD_W + 2;
    localparam int SQ_STEPS  = PROD_W / 2;
    localparam int NUM_W     = DW + 1 + FRAC_BITS;

    localparam logic signed [DW-1:0]    MAX_VAL = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0]    MIN_VAL = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF_W  = ACC_W'(2 ** (FRAC_BITS - 1));

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_SCALE  = 4'd2,
        OP_DIV    = 4'd3,
        OP_DOT    = 4'd4,
        OP_CROSS  = 4'd5,
        OP_NORM   = 4'd6,
        OP_MAG    = 4'd7,
        OP_SQUARE = 4'd8,
        OP_DIST   = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DZ  = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 ovf;
    } sat_t;

    // Item context carried through the root pipeline
    typedef struct packed {
        op_t                        op;
        logic [DW-1:0]              s;
        logic [LANES-1:0][DW-1:0]   a;
        logic [LANES-1:0][DW-1:0]   pre;
        logic [LANES-1:0]           ovf;
        logic                       big;
    } tag_t;

    // Per-lane context carried through a divider
    typedef struct packed {
        op_t           op;
        logic [DW-1:0] pre;
        logic          ovf;
        logic          neg;
        logic          dz;
    } dtag_t;

    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t                    r;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi    = ACC_W'(MAX_VAL);
        lo    = ACC_W'(MIN_VAL);
        r.val = v[DW-1:0];
        r.ovf = 1'b0;
        if (v > hi)
        begin
            r.val = MAX_VAL;
            r.ovf = 1'b1;
        end
        else if (v < lo)
        begin
            r.val = MIN_VAL;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // Drop the fraction bits, round to nearest with ties up, then clamp
    function automatic sat_t round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + HALF_W;
        t = t >>> FRAC_BITS;
        return sat32(t);
    endfunction

endpackage

FILE: hdl/v3a_if.sv
// Handshake channels of the vector ALU: command items in, result items out.
// Depends on v3a_pkg.
interface v3a_in_if import v3a_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [3:0]           op;
    logic signed [DW-1:0] a_x;
    logic signed [DW-1:0] a_y;
    logic signed [DW-1:0] a_z;
    logic signed [DW-1:0] b_x;
    logic signed [DW-1:0] b_y;
    logic signed [DW-1:0] b_z;
    logic signed [DW-1:0] scalar_in;

    modport source (output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, input ready);
    modport sink (input valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, output ready);
endinterface

interface v3a_out_if import v3a_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_y;
    logic signed [DW-1:0] r_z;
    logic [1:0]           status;

    modport source (output valid, r_x, r_y, r_z, status, input ready);
    modport sink (input valid, r_x, r_y, r_z, status, output ready);
endinterface

FILE: hdl/v3a_lane.sv
// One vector lane: operand select, two 32x32 multipliers, round and clamp.
// Depends on v3a_pkg. Three stages, all advanced together by adv.
module v3a_lane import v3a_pkg::*;
(
    input  logic                  clk,
    input  logic                  adv,
    input  op_t                   op,
    input  logic signed [DW-1:0]  a,
    input  logic signed [DW-1:0]  b,
    input  logic signed [DW-1:0]  s,
    input  logic signed [DW-1:0]  c0a,
    input  logic signed [DW-1:0]  c0b,
    input  logic signed [DW-1:0]  c1a,
    input  logic signed [DW-1:0]  c1b,
    output logic signed [PROD_W-1:0] m0,
    output sat_t                  pre,
    output logic [DW-1:0]         a_out,
    output logic                  big
);

    logic signed [DW:0]   sum_w;
    logic signed [DW:0]   diff_w;
    logic signed [DW-1:0] x0_next, y0_next, x1_next, y1_next;
    sat_t                 as_next;
    logic                 big_next;

    op_t                  op_reg [2];
    logic signed [DW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    sat_t                 as_reg [2];
    logic [DW-1:0]        a_reg [3];
    logic                 big_reg [3];
    logic signed [PROD_W-1:0] m0_reg, m1_reg;
    sat_t                 pre_next;
    sat_t                 pre_reg;
    logic signed [ACC_W-1:0] cr_w;

    always_comb
    begin
        sum_w  = {a[DW-1], a} + {b[DW-1], b};
        diff_w = {a[DW-1], a} - {b[DW-1], b};
        x0_next = '0;
        y0_next = '0;
        x1_next = '0;
        y1_next = '0;
        as_next = '0;
        case (op)
            OP_ADD:   as_next = sat32(ACC_W'(sum_w));
            OP_SUB:   as_next = sat32(ACC_W'(diff_w));
            OP_SCALE:
            begin
                x0_next = a;
                y0_next = s;
            end
            OP_DOT:
            begin
                x0_next = a;
                y0_next = b;
            end
            OP_NORM, OP_MAG, OP_SQUARE:
            begin
                x0_next = a;
                y0_next = a;
            end
            OP_CROSS:
            begin
                x0_next = c0a;
                y0_next = c0b;
                x1_next = c1a;
                y1_next = c1b;
            end
            OP_DIST:
            begin
                x0_next = diff_w[DW-1:0];
                y0_next = diff_w[DW-1:0];
            end
            default: ;
        endcase
        // difference outside the open 32-bit range
        big_next = (op == OP_DIST) &&
                   ((diff_w[DW] != diff_w[DW-1]) || (diff_w == {2'b11, {(DW-1){1'b0}}}));
    end

    always_comb
    begin
        cr_w = ACC_W'(m0_reg) - ACC_W'(m1_reg);
        case (op_reg[1])
            OP_ADD, OP_SUB:    pre_next = as_reg[1];
            OP_SCALE, OP_CROSS: pre_next = round_sat(cr_w);
            default:           pre_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg[0]  <= op;
            x0_reg     <= x0_next;
            y0_reg     <= y0_next;
            x1_reg     <= x1_next;
            y1_reg     <= y1_next;
            as_reg[0]  <= as_next;
            a_reg[0]   <= a;
            big_reg[0] <= big_next;

            op_reg[1]  <= op_reg[0];
            m0_reg     <= PROD_W'(x0_reg) * PROD_W'(y0_reg);
            m1_reg     <= PROD_W'(x1_reg) * PROD_W'(y1_reg);
            as_reg[1]  <= as_reg[0];
            a_reg[1]   <= a_reg[0];
            big_reg[1] <= big_reg[0];

            pre_reg    <= pre_next;
            a_reg[2]   <= a_reg[1];
            big_reg[2] <= big_reg[1];
        end
    end

    assign m0    = m0_reg;
    assign pre   = pre_reg;
    assign a_out = a_reg[2];
    assign big   = big_reg[2];

endmodule

FILE: hdl/v3a_sqrt.sv
// Pipelined integer square root of a 64-bit radicand, one root bit per stage,
// rounded to nearest at the output. Depends on v3a_pkg.
module v3a_sqrt import v3a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_vld,
    input  logic [PROD_W-1:0] rad,
    input  tag_t              tag_in,
    output logic              out_vld,
    output logic [DW:0]       root,
    output tag_t              tag_out
);

    logic              vld_reg  [SQ_STEPS];
    logic [DW:0]       rem_reg  [SQ_STEPS];
    logic [DW-1:0]     root_reg [SQ_STEPS];
    logic [PROD_W-1:0] rad_reg  [SQ_STEPS];
    tag_t              tag_reg  [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        logic              vld_p;
        logic [DW:0]       rem_p;
        logic [DW-1:0]     root_p;
        logic [PROD_W-1:0] rad_p;
        tag_t              tag_p;
        logic [DW+2:0]     rem2;
        logic [DW+2:0]     trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign vld_p  = in_vld;
            assign rem_p  = '0;
            assign root_p = '0;
            assign rad_p  = rad;
            assign tag_p  = tag_in;
        end
        else
        begin : g_next
            assign vld_p  = vld_reg[k-1];
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign rad_p  = rad_reg[k-1];
            assign tag_p  = tag_reg[k-1];
        end

        assign rem2  = {rem_p, rad_p[PROD_W-1 -: 2]};
        assign trial = {1'b0, root_p, 2'b01};
        assign ge    = (rem2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_p;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= ge ? (DW+1)'(rem2 - trial) : rem2[DW:0];
                root_reg[k] <= {root_p[DW-2:0], ge};
                rad_reg[k]  <= rad_p << 2;
                tag_reg[k]  <= tag_p;
            end
        end
    end

    // bump the floor root when the remainder passes it
    assign root    = {1'b0, root_reg[SQ_STEPS-1]} +
                     (DW+1)'(rem_reg[SQ_STEPS-1] > {1'b0, root_reg[SQ_STEPS-1]});
    assign out_vld = vld_reg[SQ_STEPS-1];
    assign tag_out = tag_reg[SQ_STEPS-1];

endmodule

FILE: hdl/v3a_div.sv
// Pipelined restoring divider for one lane: (|a| << FRAC_BITS + den/2) / den,
// one quotient bit per stage after a setup stage. Depends on v3a_pkg.
module v3a_div import v3a_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  logic [DW-1:0]    mag,
    input  logic [DW-1:0]    den,
    input  dtag_t            tag_in,
    output logic             out_vld,
    output logic [NUM_W-1:0] quo,
    output dtag_t            tag_out
);

    logic             vld_reg [NUM_W+1];
    logic [DW-1:0]    rem_reg [NUM_W+1];
    logic [NUM_W-1:0] nq_reg  [NUM_W+1];
    logic [DW-1:0]    den_reg [NUM_W+1];
    dtag_t            tag_reg [NUM_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_vld;
    end

    // setup: scaled numerator plus half the divisor
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= NUM_W'({mag, {FRAC_BITS{1'b0}}}) + NUM_W'(den >> 1);
            den_reg[0] <= den;
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar k = 1; k <= NUM_W; k++)
    begin : g_step
        logic [DW:0] rem2;
        logic        ge;

        assign rem2 = {rem_reg[k-1], nq_reg[k-1][NUM_W-1]};
        assign ge   = (rem2 >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= ge ? DW'(rem2 - {1'b0, den_reg[k-1]}) : rem2[DW-1:0];
                nq_reg[k]  <= {nq_reg[k-1][NUM_W-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_vld = vld_reg[NUM_W];
    assign quo     = nq_reg[NUM_W];
    assign tag_out = tag_reg[NUM_W];

endmodule

FILE: hdl/vector3_alu_core.sv
// Top level of the three-component vector ALU in signed fixed point.
// Depends on v3a_pkg, v3a_if, v3a_lane, v3a_sqrt and v3a_div.
//
//  channel | direction | carries
//  --------+-----------+-------------------------------------------------
//  cmd     | in        | op, a_x..a_z, b_x..b_z, scalar_in
//  res     | out       | r_x, r_y, r_z, status
//
// Pipeline: one item enters per cycle unless the pipeline stalls; an accepted item
//   passes in order through the lanes (3 stages), the root pipeline (32 stages),
//   one post-root stage, the per-lane dividers (34 + FRAC_BITS) and the output
//   register.
// Reset: rst_n clears every valid bit; the datapath is not reset.
// Stalls: the whole pipeline holds while a result waits on res; cmd.ready
//   drops only then and is formed from res.ready without a register between.
module vector3_alu_core import v3a_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    v3a_in_if.sink    cmd,
    v3a_out_if.source res
);

    // Pipeline advance: hold everything while a result is refused
    logic adv;
    logic out_vld_reg;

    assign adv       = !out_vld_reg || res.ready;
    assign cmd.ready = adv;

    // Front control: valid, op and scalar follow the lanes through three stages
    logic [2:0]    fr_vld_reg;
    op_t           fr_op_reg [3];
    logic [DW-1:0] fr_s_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_vld_reg <= '0;
        else if (adv)
            fr_vld_reg <= {fr_vld_reg[1:0], cmd.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fr_op_reg[0] <= op_t'(cmd.op);
            fr_s_reg[0]  <= cmd.scalar_in;
            for (int i = 1; i < 3; i++)
            begin
                fr_op_reg[i] <= fr_op_reg[i-1];
                fr_s_reg[i]  <= fr_s_reg[i-1];
            end
        end
    end

    // Lanes: one per component; lane l computes component l of the cross product
    logic signed [DW-1:0]     av [LANES];
    logic signed [DW-1:0]     bv [LANES];
    logic signed [PROD_W-1:0] m0 [LANES];
    sat_t                     lpre [LANES];
    logic [DW-1:0]            la [LANES];
    logic [LANES-1:0]         lbig;

    assign av[0] = cmd.a_x;
    assign av[1] = cmd.a_y;
    assign av[2] = cmd.a_z;
    assign bv[0] = cmd.b_x;
    assign bv[1] = cmd.b_y;
    assign bv[2] = cmd.b_z;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        v3a_lane u_lane
        (
            .clk   (clk),
            .adv   (adv),
            .op    (op_t'(cmd.op)),
            .a     (av[l]),
            .b     (bv[l]),
            .s     (cmd.scalar_in),
            .c0a   (av[(l+1)%LANES]),
            .c0b   (bv[(l+2)%LANES]),
            .c1a   (av[(l+2)%LANES]),
            .c1b   (bv[(l+1)%LANES]),
            .m0    (m0[l]),
            .pre   (lpre[l]),
            .a_out (la[l]),
            .big   (lbig[l])
        );
    end

    // Merge: sum the first products of all lanes (dot, squared length, d^2)
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            acc_reg <= ACC_W'(m0[0]) + ACC_W'(m0[1]) + ACC_W'(m0[2]);
    end

    // Build the item context for the root pipeline; scalar results sit in lane 0
    tag_t sq_tag_in;
    sat_t acc_rs;

    always_comb
    begin
        acc_rs       = round_sat(acc_reg);
        sq_tag_in.op = fr_op_reg[2];
        sq_tag_in.s  = fr_s_reg[2];
        sq_tag_in.big = |lbig;
        for (int l = 0; l < LANES; l++)
        begin
            sq_tag_in.a[l]   = la[l];
            sq_tag_in.pre[l] = lpre[l].val;
            sq_tag_in.ovf[l] = lpre[l].ovf;
        end
        if ((fr_op_reg[2] == OP_DOT) || (fr_op_reg[2] == OP_SQUARE))
        begin
            sq_tag_in.pre[0] = acc_rs.val;
            sq_tag_in.ovf[0] = acc_rs.ovf;
        end
    end

    logic        sq_vld;
    logic [DW:0] sq_root;
    tag_t        sq_tag;

    v3a_sqrt u_sqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (fr_vld_reg[2]),
        .rad     (acc_reg[PROD_W-1:0]),
        .tag_in  (sq_tag_in),
        .out_vld (sq_vld),
        .root    (sq_root),
        .tag_out (sq_tag)
    );

    // Post-root stage: finish magnitude and distance, pick the divisor,
    // take component magnitudes for the dividers
    tag_t          pt_next;
    sat_t          root_rs;
    logic [DW-1:0] den_next;
    logic [DW-1:0] amag_next [LANES];

    logic          post_vld_reg;
    tag_t          post_tag_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] amag_reg [LANES];

    always_comb
    begin
        pt_next = sq_tag;
        root_rs = sat32(ACC_W'(sq_root));
        case (sq_tag.op)
            OP_MAG:
            begin
                pt_next.pre[0] = root_rs.val;
                pt_next.ovf[0] = root_rs.ovf;
            end
            OP_DIST:
            begin
                if (sq_tag.big)
                begin
                    pt_next.pre[0] = MAX_VAL;
                    pt_next.ovf[0] = 1'b1;
                end
                else
                begin
                    pt_next.pre[0] = root_rs.val;
                    pt_next.ovf[0] = root_rs.ovf;
                end
            end
            default: ;
        endcase
        if (sq_tag.op == OP_NORM)
            den_next = sq_root[DW-1:0];
        else
            den_next = sq_tag.s[DW-1] ? (~sq_tag.s + 1'b1) : sq_tag.s;
        for (int l = 0; l < LANES; l++)
            amag_next[l] = sq_tag.a[l][DW-1] ? (~sq_tag.a[l] + 1'b1) : sq_tag.a[l];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            post_vld_reg <= 1'b0;
        else if (adv)
            post_vld_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            post_tag_reg <= pt_next;
            den_reg      <= den_next;
            for (int l = 0; l < LANES; l++)
                amag_reg[l] <= amag_next[l];
        end
    end

    // Dividers: one per lane; a zero divisor marks a divide or normalise item
    logic             is_div;
    logic             dz;
    logic             sneg;
    dtag_t            dtag_in [LANES];
    logic [LANES-1:0] dv_vld;
    logic [NUM_W-1:0] dquo [LANES];
    dtag_t            dtag  [LANES];

    assign is_div = (post_tag_reg.op == OP_DIV) || (post_tag_reg.op == OP_NORM);
    assign dz     = is_div && (den_reg == '0);
    assign sneg   = (post_tag_reg.op == OP_DIV) && post_tag_reg.s[DW-1];

    for (genvar l = 0; l < LANES; l++)
    begin : g_div
        assign dtag_in[l].op  = post_tag_reg.op;
        assign dtag_in[l].pre = post_tag_reg.pre[l];
        assign dtag_in[l].ovf = post_tag_reg.ovf[l];
        assign dtag_in[l].neg = post_tag_reg.a[l][DW-1] ^ sneg;
        assign dtag_in[l].dz  = dz;

        v3a_div u_div
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_vld  (post_vld_reg),
            .mag     (amag_reg[l]),
            .den     (den_reg),
            .tag_in  (dtag_in[l]),
            .out_vld (dv_vld[l]),
            .quo     (dquo[l]),
            .tag_out (dtag[l])
        );
    end

    // Output stage: sign and clamp quotients, select per op, fold the status
    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(MAX_VAL);
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'({1'b0, MIN_VAL});

    logic [DW-1:0] r_next [LANES];
    logic [LANES-1:0] ovf_next;
    status_t       st_next;

    logic [DW-1:0] r_reg [LANES];
    status_t       st_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            r_next[l]   = dtag[l].pre;
            ovf_next[l] = dtag[l].ovf;
            if ((dtag[l].op == OP_DIV) || (dtag[l].op == OP_NORM))
            begin
                ovf_next[l] = 1'b0;
                if (dtag[l].dz)
                    r_next[l] = '0;
                else if (!dtag[l].neg)
                begin
                    if (dquo[l] > POS_LIM)
                    begin
                        r_next[l]   = MAX_VAL;
                        ovf_next[l] = 1'b1;
                    end
                    else
                        r_next[l] = dquo[l][DW-1:0];
                end
                else
                begin
                    if (dquo[l] > NEG_LIM)
                    begin
                        r_next[l]   = MIN_VAL;
                        ovf_next[l] = 1'b1;
                    end
                    else
                        r_next[l] = ~dquo[l][DW-1:0] + 1'b1;
                end
            end
        end
        if (dtag[0].dz)
            st_next = ST_DZ;
        else if (|ovf_next)
            st_next = ST_SAT;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= &dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
                r_reg[l] <= r_next[l];
            st_reg <= st_next;
        end
    end

    assign res.valid  = out_vld_reg;
    assign res.r_x    = r_reg[0];
    assign res.r_y    = r_reg[1];
    assign res.r_z    = r_reg[2];
    assign res.status = st_reg;

    // A divide-by-zero result carries zeros in every lane
    a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == ST_DZ) |->
            (res.r_x == '0) && (res.r_y == '0) && (res.r_z == '0))
        else $error("divide-by-zero result with nonzero lane");

    // A saturated result has at least one lane at a limit
    a_sat_limit : assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == ST_SAT) |->
            (res.r_x == MAX_VAL) || (res.r_x == MIN_VAL) ||
            (res.r_y == MAX_VAL) || (res.r_y == MIN_VAL) ||
            (res.r_z == MAX_VAL) || (res.r_z == MIN_VAL))
        else $error("saturation status without a clamped lane");

endmodule
